// ===== sv/positional_list_engine_macros.svh =====
// Assertion macros for the positional list engine.
// Define ASSERT_OFF to compile every check away.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// cons must hold in the same cycle as ante
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ple_pkg.sv =====
`timescale 1ns / 1ps
package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;

	typedef logic signed [31:0] word_t;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	localparam logic [2:0] KIND_INSERT   = 3'd0;
	localparam logic [2:0] KIND_DELETE   = 3'd1;
	localparam logic [2:0] KIND_SEARCH   = 3'd2;
	localparam logic [2:0] KIND_MIDDLE   = 3'd3;
	localparam logic [2:0] KIND_TRAVERSE = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_BADPOS   = 3'd4;

	typedef struct packed {
		logic [2:0]       kind;
		word_t            item_value;
		logic [POS_W-1:0] position;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		word_t            out_value;
		logic [POS_W-1:0] out_position;
		logic             last;
		logic [POS_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ROTATE,
		CELL_INSERT,
		CELL_DELETE
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] at;
		word_t            value;
	} cell_ctrl_t;

endpackage

// ===== sv/ple_cell.sv =====
`timescale 1ns / 1ps
module ple_cell (
	input  logic                          clk,
	input  ple_pkg::cell_ctrl_t           ctrl,
	input  logic [ple_pkg::IDX_W-1:0]     idx,
	input  ple_pkg::word_t                left,
	input  ple_pkg::word_t                right,
	output ple_pkg::word_t                value
);

	ple_pkg::word_t                value_q;
	logic [ple_pkg::POS_W-1:0]     idx_ext;

	assign idx_ext = ple_pkg::POS_W'(idx);
	assign value   = value_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			ple_pkg::CELL_HOLD: begin
			end
			ple_pkg::CELL_ROTATE: begin
				value_q <= right;
			end
			ple_pkg::CELL_INSERT: begin
				if (idx_ext > ctrl.at) begin
					value_q <= left;
				end else if (idx_ext == ctrl.at) begin
					value_q <= ctrl.value;
				end
			end
			ple_pkg::CELL_DELETE: begin
				if (idx_ext >= ctrl.at) begin
					value_q <= right;
				end
			end
		endcase
	end

endmodule

// ===== sv/ple_chain.sv =====
`timescale 1ns / 1ps
module ple_chain (
	input  logic                 clk,
	input  ple_pkg::cell_ctrl_t  ctrl,
	output ple_pkg::word_t       head
);

	ple_pkg::word_t vals [ple_pkg::CAPACITY];

	// ring: each cell sees both neighbours, wrapping at the ends
	for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
		localparam int L = (i + ple_pkg::CAPACITY - 1) % ple_pkg::CAPACITY;
		localparam int R = (i + 1) % ple_pkg::CAPACITY;
		ple_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.idx   (ple_pkg::IDX_W'(i)),
			.left  (vals[L]),
			.right (vals[R]),
			.value (vals[i])
		);
	end

	assign head = vals[0];

endmodule

// ===== sv/positional_list_engine.sv =====
`timescale 1ns / 1ps
`include "positional_list_engine_macros.svh"
// Positional list engine. Holds up to CAPACITY signed 32-bit entries in a ring
// of cells, one entry per cell, position 1 in the head cell. Insert and delete
// shift the cells beyond the position by one place, so these words, and every
// error or empty-list case, give one result word. Search, middle and traverse
// rotate the whole ring past the head cell in CAPACITY rotation steps, after
// which the ring is back in its home alignment. A rotation step waits while
// the result register is held by rsp_stall, so stalls on the result side
// lengthen a walk. Traverse gives one result word per entry with last set on
// the final one; everything else gives exactly one. A new command word is taken
// only when no walk is running and the result register is empty or being
// drained in the same cycle; cmd_stall is held high while arst_n is low. There
// is no clearing pass: entries are undefined until written and only occupied
// cells are read.
module positional_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  ple_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ple_pkg::rsp_t  rsp
);

	typedef enum logic {
		IDLE,
		WALK
	} state_t;

	state_t                       state_q;
	logic [ple_pkg::CNT_W-1:0]    count_q;
	logic [ple_pkg::IDX_W-1:0]    step_q;
	logic                         found_q;
	logic [2:0]                   kind_q;
	ple_pkg::word_t               key_q;
	logic                         rsp_valid_q;
	ple_pkg::rsp_t                rsp_q;

	logic                         out_free;
	logic                         accept;
	logic                         walk_adv;
	logic                         last_step;
	logic [ple_pkg::POS_W-1:0]    pos_m1;
	logic [ple_pkg::POS_W-1:0]    count_pos;
	logic [ple_pkg::POS_W-1:0]    ins_at;
	logic [ple_pkg::CNT_W-1:0]    step_cnt;
	logic [ple_pkg::POS_W-1:0]    step_pos1;
	logic                         in_list;
	ple_pkg::word_t               head;
	ple_pkg::cell_ctrl_t          ctrl;

	// handshake: the result register parts the two sides; nothing taken in reset
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = !(arst_n && (state_q == IDLE) && out_free);
	assign accept    = cmd_valid && !cmd_stall;
	assign walk_adv  = (state_q == WALK) && out_free;
	assign last_step = (step_q == ple_pkg::IDX_W'(ple_pkg::CAPACITY - 1));

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// position arithmetic
	assign pos_m1    = cmd.position - 1'b1;
	assign count_pos = ple_pkg::POS_W'(count_q);
	assign ins_at    = (pos_m1 > count_pos) ? count_pos : pos_m1;   // beyond end appends
	assign step_cnt  = ple_pkg::CNT_W'(step_q);
	assign step_pos1 = ple_pkg::POS_W'(step_q) + 1'b1;
	assign in_list   = step_cnt < count_q;

	// command to the cell row
	always_comb begin
		ctrl.op    = ple_pkg::CELL_HOLD;
		ctrl.at    = pos_m1;
		ctrl.value = cmd.item_value;
		if (accept) begin
			if (cmd.kind == ple_pkg::KIND_INSERT && cmd.position != '0 &&
				count_q < ple_pkg::CAP_COUNT) begin
				ctrl.op = ple_pkg::CELL_INSERT;
				ctrl.at = ins_at;
			end else if (cmd.kind == ple_pkg::KIND_DELETE && cmd.position != '0 &&
				count_q != '0 && pos_m1 < count_pos) begin
				ctrl.op = ple_pkg::CELL_DELETE;
			end
		end else if (walk_adv) begin
			ctrl.op = ple_pkg::CELL_ROTATE;
		end
	end

	ple_chain u_chain (
		.clk  (clk),
		.ctrl (ctrl),
		.head (head)
	);

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			kind_q      <= '0;
			key_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.status       <= ple_pkg::ST_OK;
						rsp_q.out_value    <= '0;
						rsp_q.out_position <= '0;
						rsp_q.last         <= 1'b1;
						rsp_q.entry_count  <= count_pos;
						case (cmd.kind) inside
							ple_pkg::KIND_INSERT: begin
								if (cmd.position == '0) begin
									rsp_q.status <= ple_pkg::ST_BADPOS;
								end else if (count_q >= ple_pkg::CAP_COUNT) begin
									rsp_q.status <= ple_pkg::ST_FULL;
								end else begin
									count_q           <= count_q + 1'b1;
									rsp_q.entry_count <= count_pos + 1'b1;
								end
							end
							ple_pkg::KIND_DELETE: begin
								if (cmd.position == '0) begin
									rsp_q.status <= ple_pkg::ST_BADPOS;
								end else if (count_q == '0) begin
									rsp_q.status <= ple_pkg::ST_EMPTY;
								end else if (pos_m1 >= count_pos) begin
									rsp_q.status <= ple_pkg::ST_NOTFOUND;
								end else begin
									count_q           <= count_q - 1'b1;
									rsp_q.entry_count <= count_pos - 1'b1;
								end
							end
							ple_pkg::KIND_SEARCH, ple_pkg::KIND_MIDDLE,
							ple_pkg::KIND_TRAVERSE: begin
								if (count_q == '0) begin
									rsp_q.status <= (cmd.kind == ple_pkg::KIND_SEARCH) ?
										ple_pkg::ST_NOTFOUND : ple_pkg::ST_EMPTY;
								end else begin
									// results come from the walk
									rsp_valid_q <= 1'b0;
									state_q     <= WALK;
									step_q      <= '0;
									found_q     <= 1'b0;
									kind_q      <= cmd.kind;
									key_q       <= cmd.item_value;
								end
							end
							default: begin
								rsp_q.status <= ple_pkg::ST_BADPOS;
							end
						endcase
					end
				end
				WALK: begin
					if (walk_adv) begin
						step_q <= step_q + 1'b1;
						if (last_step) begin
							state_q <= IDLE;
						end
						rsp_q.status       <= ple_pkg::ST_OK;
						rsp_q.out_value    <= '0;
						rsp_q.out_position <= '0;
						rsp_q.last         <= 1'b1;
						rsp_q.entry_count  <= count_pos;
						case (kind_q)
							ple_pkg::KIND_TRAVERSE: begin
								if (in_list) begin
									rsp_valid_q        <= 1'b1;
									rsp_q.out_value    <= head;
									rsp_q.out_position <= step_pos1;
									rsp_q.last         <= (step_pos1 == count_pos);
								end
							end
							ple_pkg::KIND_MIDDLE: begin
								if (step_cnt == (count_q >> 1)) begin
									rsp_valid_q     <= 1'b1;
									rsp_q.out_value <= head;
								end
							end
							default: begin
								// search: first hit wins, miss reported at the end
								if (in_list && !found_q && head == key_q) begin
									found_q            <= 1'b1;
									rsp_valid_q        <= 1'b1;
									rsp_q.out_position <= step_pos1;
								end else if (last_step && !found_q) begin
									rsp_valid_q  <= 1'b1;
									rsp_q.status <= ple_pkg::ST_NOTFOUND;
								end
							end
						endcase
					end
				end
			endcase
		end
	end

	// checks
	`ASSERT_HOLDS(a_count_cap, clk, arst_n, count_q <= ple_pkg::CAP_COUNT)
	`ASSERT_NEXT(a_walk_count, clk, arst_n, state_q == WALK, $stable(count_q))
	`ASSERT_IMPL(a_walk_start, clk, arst_n, $rose(state_q == WALK), step_q == '0)
	`ASSERT_IMPL(a_pos_bound, clk, arst_n, rsp_valid_q, rsp_q.out_position <= rsp_q.entry_count)

endmodule
